/* design/med_predictive_pixel_coder_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the MED pixel coder core checker.
// Every macro samples on i_clk.
// ----------------------------------------------------------------------------
`ifndef MED_PREDICTIVE_PIXEL_CODER_CORE_ASSERT_SVH
`define MED_PREDICTIVE_PIXEL_CODER_CORE_ASSERT_SVH

// Overlapping implication. Not checked while reset is held.
`define MPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication. Not checked while reset is held.
`define MPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define MPC_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mpc_pkg.sv */
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types and constants for the MED predictive pixel coder.
// ----------------------------------------------------------------------------
`default_nettype none

package mpc_pkg;

    // Sample and residual widths
    localparam int PIX_W   = 8;
    localparam int RES_W   = 9;

    // Frame height limits
    localparam int HGT_W        = 13;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_LIMIT = 4096;

    // Configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 13;

    // Stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_MODE     = 2'd0,
        CFG_CHANNELS = 2'd1,
        CFG_WIDTH    = 2'd2,
        CFG_HEIGHT   = 2'd3
    } t_cfg_idx;

    // Coder modes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Neighbour set for one sample: left, upper, upper-left
    typedef struct packed {
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] c;
    } t_nbr;

    // Result of coding one sample
    typedef struct packed {
        logic [RES_W-1:0] residual;
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] prediction;
    } t_code;

endpackage

`default_nettype wire

/* design/med_predictive_pixel_coder_core.sv */
// ----------------------------------------------------------------------------
// med_predictive_pixel_coder_core
// Lossless MED predictive coder for raster images with interleaved channels.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------------
//  s stream | in        | in_pixel, in_residual
//  m stream | out       | out_residual, out_pixel, prediction; tlast=frame_end
//  cfg      | in        | coder_mode, num_channels, image_width, image_height
//
//  One sample per clock while the output is not stalled; a sample goes through
//  the middle stage and the output register. The line store is read on accept
//  and written back as the sample moves on; a same-entry read is forwarded.
//  Reset clears position counters, neighbour registers and both valid flags.
//  A stalled output holds the middle stage; input is still taken while the
//  output register is being emptied in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module med_predictive_pixel_coder_core #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 3
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // [7:0] in_pixel, [16:8] in_residual, [23:17] zero
    input  wire logic [mpc_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // Output stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [8:0] out_residual, [16:9] out_pixel, [24:17] prediction, [31:25] zero
    output logic      [mpc_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic                                  o_m_tlast,
    // Configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [mpc_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  wire logic [mpc_pkg::CFG_DW-1:0]       i_cfg_wdata
);

    import mpc_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHC_W = $clog2(MAX_CHANNELS + 1);
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WC_W  = $clog2(MAX_WIDTH + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers
    logic              r_mode;
    logic [1:0]        r_chans_cfg;
    logic [11:0]       r_width_cfg;
    logic [HGT_W-1:0]  r_height_cfg;

    // Position counters
    logic [CH_W-1:0]   r_chan, n_chan;
    logic [COL_W-1:0]  r_col,  n_col;
    logic [ROW_W-1:0]  r_row,  n_row;

    // Middle stage
    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_pixel;
    logic [RES_W-1:0]  r_s1_resid;
    logic [CH_W-1:0]   r_s1_ch;
    logic              r_s1_has_up;
    logic              r_s1_has_left;
    logic              r_s1_last;
    logic [AW-1:0]     r_s1_addr;

    // Forwarding of a same-cycle write to the entry being read
    logic              r_fwd;
    logic [PIX_W-1:0]  r_fwd_data;

    // Per-channel neighbour registers
    logic [PIX_W-1:0]  r_left [MAX_CHANNELS];
    logic [PIX_W-1:0]  r_upleft [MAX_CHANNELS];

    // Output register
    logic              r_out_valid;
    logic [RES_W-1:0]  r_out_resid;
    logic [PIX_W-1:0]  r_out_pixel;
    logic [PIX_W-1:0]  r_out_pred;
    logic              r_out_last;

    logic [CHC_W-1:0]  w_chans;
    logic [WC_W-1:0]   w_width;
    logic [HGT_W-1:0]  w_height;
    logic              w_chan_wrap;
    logic              w_col_wrap;
    logic              w_row_wrap;
    logic              w_accept;
    logic              w_s1_go;
    logic [AW-1:0]     w_rd_addr;
    logic [PIX_W-1:0]  w_ram_q;
    logic [PIX_W-1:0]  w_above;
    t_nbr              w_nbr;
    t_code             w_code;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_ENCODE;
            r_chans_cfg  <= 2'd3;
            r_width_cfg  <= 12'd640;
            r_height_cfg <= 13'd480;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MODE:     r_mode       <= i_cfg_wdata[0];
                CFG_CHANNELS: r_chans_cfg  <= i_cfg_wdata[1:0];
                CFG_WIDTH:    r_width_cfg  <= i_cfg_wdata[11:0];
                CFG_HEIGHT:   r_height_cfg <= i_cfg_wdata[HGT_W-1:0];
                default:      r_mode       <= r_mode;
            endcase
        end
    end

    // Effective limits: zero acts as one, large values saturate
    always_comb begin
        if (r_chans_cfg == 2'd0) begin
            w_chans = CHC_W'(1);
        end else if (r_chans_cfg > MAX_CHANNELS) begin
            w_chans = CHC_W'(MAX_CHANNELS);
        end else begin
            w_chans = CHC_W'(r_chans_cfg);
        end
        if (r_width_cfg == 12'd0) begin
            w_width = WC_W'(1);
        end else if (r_width_cfg > MAX_WIDTH) begin
            w_width = WC_W'(MAX_WIDTH);
        end else begin
            w_width = WC_W'(r_width_cfg);
        end
        if (r_height_cfg == '0) begin
            w_height = HGT_W'(1);
        end else if (r_height_cfg > HEIGHT_LIMIT) begin
            w_height = HGT_W'(HEIGHT_LIMIT);
        end else begin
            w_height = r_height_cfg;
        end
    end

    // Handshake
    assign w_s1_go    = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || w_s1_go;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Position stepping
    always_comb begin
        w_chan_wrap = (CHC_W'(r_chan) + CHC_W'(1)) >= w_chans;
        w_col_wrap  = (WC_W'(r_col) + WC_W'(1)) >= w_width;
        w_row_wrap  = ({1'b0, r_row} + HGT_W'(1)) >= w_height;
        n_chan = r_chan;
        n_col  = r_col;
        n_row  = r_row;
        if (w_chan_wrap) begin
            n_chan = '0;
            if (w_col_wrap) begin
                n_col = '0;
                n_row = w_row_wrap ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end else begin
            n_chan = r_chan + CH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (w_accept) begin
            r_chan <= n_chan;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

    // Line store: entry col * MAX_CHANNELS + channel
    assign w_rd_addr = AW'(AW'(r_col) * MAX_CHANNELS + AW'(r_chan));

    mpc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_s1_go),
        .i_waddr (r_s1_addr),
        .i_wdata (w_code.pixel),
        .i_re    (w_accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_q)
    );

    // Middle stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= w_s1_go && (r_s1_addr == w_rd_addr);
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Middle stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pixel    <= i_s_tdata[PIX_W-1:0];
            r_s1_resid    <= i_s_tdata[PIX_W +: RES_W];
            r_s1_ch       <= r_chan;
            r_s1_has_up   <= (r_row != '0);
            r_s1_has_left <= (r_col != '0);
            r_s1_last     <= w_chan_wrap && w_col_wrap && w_row_wrap;
            r_s1_addr     <= w_rd_addr;
            r_fwd_data    <= w_code.pixel;
        end
    end

    // Neighbour selection; edges read as zero
    assign w_above = r_fwd ? r_fwd_data : w_ram_q;

    always_comb begin
        w_nbr.a = r_s1_has_left ? r_left[r_s1_ch] : '0;
        w_nbr.b = r_s1_has_up ? w_above : '0;
        w_nbr.c = (r_s1_has_up && r_s1_has_left) ? r_upleft[r_s1_ch] : '0;
    end

    mpc_coder u_coder (
        .i_mode     (r_mode),
        .i_nbr      (w_nbr),
        .i_pixel    (r_s1_pixel),
        .i_residual (r_s1_resid),
        .o_code     (w_code)
    );

    // Neighbour write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_left[i]   <= '0;
                r_upleft[i] <= '0;
            end
        end else if (w_s1_go) begin
            r_left[r_s1_ch]   <= w_code.pixel;
            r_upleft[r_s1_ch] <= w_above;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            r_out_resid <= w_code.residual;
            r_out_pixel <= w_code.pixel;
            r_out_pred  <= w_code.prediction;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - RES_W - 2 * PIX_W){1'b0}},
                         r_out_pred, r_out_pixel, r_out_resid};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

/* design/mpc_ram.sv */
// ----------------------------------------------------------------------------
// mpc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 6144,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/mpc_coder.sv */
// ----------------------------------------------------------------------------
// mpc_coder
// Median edge detector prediction and residual encode / decode of one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_coder (
    input  wire logic                 i_mode,
    input  wire mpc_pkg::t_nbr        i_nbr,
    input  wire logic [7:0]           i_pixel,
    input  wire logic [8:0]           i_residual,
    output mpc_pkg::t_code            o_code
);

    import mpc_pkg::*;

    logic [PIX_W-1:0] w_lo;
    logic [PIX_W-1:0] w_hi;
    logic [PIX_W+1:0] w_grad;
    logic [PIX_W-1:0] w_pred;

    // Median edge detector
    always_comb begin
        w_lo   = (i_nbr.a < i_nbr.b) ? i_nbr.a : i_nbr.b;
        w_hi   = (i_nbr.a < i_nbr.b) ? i_nbr.b : i_nbr.a;
        w_grad = {2'b00, i_nbr.a} + {2'b00, i_nbr.b} - {2'b00, i_nbr.c};
        if (i_nbr.c >= w_hi) begin
            w_pred = w_lo;
        end else if (i_nbr.c <= w_lo) begin
            w_pred = w_hi;
        end else begin
            w_pred = w_grad[PIX_W-1:0];
        end
    end

    // Encode: residual = sample - prediction; decode: sample = residual + prediction
    always_comb begin
        o_code.prediction = w_pred;
        if (i_mode == MODE_ENCODE) begin
            o_code.pixel    = i_pixel;
            o_code.residual = {1'b0, i_pixel} - {1'b0, w_pred};
        end else begin
            o_code.pixel    = i_residual[PIX_W-1:0] + w_pred;
            o_code.residual = '0;
        end
    end

endmodule

`default_nettype wire

/* design/mpc_checker.sv */
// ----------------------------------------------------------------------------
// mpc_checker
// Port-level checks for the MED pixel coder core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    input  wire logic                             o_s_tready,
    input  wire logic                             o_m_tvalid,
    input  wire logic                             i_m_tready,
    input  wire logic [mpc_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input  wire logic                             o_m_tlast,
    input  wire logic                             i_cfg_we,
    input  wire logic [mpc_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  wire logic [mpc_pkg::CFG_DW-1:0]       i_cfg_wdata
);

    import mpc_pkg::*;

    `include "med_predictive_pixel_coder_core_assert.svh"

    logic             r_mode;
    logic [1:0]       r_cnt;
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_stall;
    logic [M_TDATA_W:0] w_out_word;
    logic [RES_W-1:0] w_diff;
    logic             w_res_ok;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_acc  = o_m_tvalid && i_m_tready;
    assign w_stall    = o_m_tvalid && !i_m_tready;
    assign w_out_word = {o_m_tlast, o_m_tdata};

    // Shadow of the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
        end else if (i_cfg_we && (t_cfg_idx'(i_cfg_addr) == CFG_MODE)) begin
            r_mode <= i_cfg_wdata[0];
        end
    end

    // Transactions in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(w_in_acc) - 2'(w_out_acc);
        end
    end

    // Residual follows from pixel and prediction when encoding, zero when decoding
    assign w_diff   = {1'b0, o_m_tdata[16:9]} - {1'b0, o_m_tdata[24:17]};
    assign w_res_ok = (r_mode == MODE_ENCODE) ? (o_m_tdata[8:0] == w_diff)
                                              : (o_m_tdata[8:0] == '0);

    `MPC_ASSERT_NEXT(a_out_hold, w_stall, o_m_tvalid && $stable(w_out_word), "output not held")
    `MPC_ASSERT_RST(a_rst_clear, !i_rst_n, !o_m_tvalid, "output valid after reset")
    `MPC_ASSERT_SAME(a_no_invent, o_m_tvalid, r_cnt != 2'd0, "output without input")
    `MPC_ASSERT_SAME(a_res_mode, o_m_tvalid, w_res_ok, "residual inconsistent with mode")
    `MPC_ASSERT_SAME(a_flow, i_m_tready && r_cnt != 2'd3, o_s_tready, "input stalled")

endmodule

bind med_predictive_pixel_coder_core mpc_checker u_mpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tlast   (o_m_tlast),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_addr  (i_cfg_addr),
    .i_cfg_wdata (i_cfg_wdata)
);

`default_nettype wire
